@@ rtl/rtm_pkg.sv @@
// Package for the repetition timing monitor: transaction types, request
// codes, run mode codes and the configuration bundle.
// Depends on nothing; every other file in rtl/ uses it.
`timescale 1ns / 1ps

package rtm_pkg;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_START_WAVE  = 3'd0;
    localparam logic [2:0] REQ_BEGIN_BLOCK = 3'd1;
    localparam logic [2:0] REQ_END_BLOCK   = 3'd2;
    localparam logic [2:0] REQ_ADD_BYTES   = 3'd3;
    localparam logic [2:0] REQ_CHECK       = 3'd4;

    // Run mode codes.
    localparam logic [1:0] MODE_UNINIT    = 2'd0;
    localparam logic [1:0] MODE_TESTING   = 2'd1;
    localparam logic [1:0] MODE_COMPLETED = 2'd2;
    localparam logic [1:0] MODE_ERROR     = 2'd3;

    // Fault code bits.
    localparam logic [1:0] FAULT_NONE       = 2'b00;
    localparam logic [1:0] FAULT_UNBALANCED = 2'b01;
    localparam logic [1:0] FAULT_BYTES      = 2'b10;

    // Configuration register indexes.
    localparam logic REG_TARGET_BYTES = 1'b0;
    localparam logic REG_TRY_DURATION = 1'b1;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 64;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] timestamp;
        logic [31:0] byte_amount;
    } in_item_t;

    typedef struct packed {
        logic        still_testing;
        logic [1:0]  run_mode;
        logic [1:0]  fault_code;
        logic        new_minimum;
        logic [31:0] iterations;
        logic [63:0] fastest_time;
        logic [63:0] slowest_time;
        logic [63:0] summed_time;
    } out_item_t;

    typedef struct packed {
        logic [63:0] target_bytes;
        logic [63:0] try_duration_ticks;
    } cfg_t;

endpackage

@@ rtl/rtm_cfg_regs.sv @@
// APB-style configuration register file for the repetition timing monitor.
// Holds the target byte count and the idle timeout. Depends on rtm_pkg.
`timescale 1ns / 1ps

module rtm_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtm_pkg::PADDR_W-1:0]   paddr,
    input  logic [rtm_pkg::PDATA_W-1:0]   pwdata,
    output logic [rtm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output rtm_pkg::cfg_t                 cfg
);

    logic [63:0] target_bytes_reg;
    logic [63:0] try_duration_reg;
    logic        wr_en;
    logic        reg_sel;

    // Registers sit 8 bytes apart; bit 3 of the address picks one.
    assign reg_sel = paddr[3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_bytes_reg <= '0;
            try_duration_reg <= '0;
        end else if (wr_en) begin
            if (reg_sel == rtm_pkg::REG_TARGET_BYTES) begin
                target_bytes_reg <= pwdata;
            end else begin
                try_duration_reg <= pwdata;
            end
        end
    end

    assign prdata = (reg_sel == rtm_pkg::REG_TRY_DURATION) ? try_duration_reg
                                                           : target_bytes_reg;

    assign cfg.target_bytes       = target_bytes_reg;
    assign cfg.try_duration_ticks = try_duration_reg;

endmodule

@@ rtl/rtm_core.sv @@
// Test state and statistics of the repetition timing monitor. Applies one
// event per cycle while step is high and forms its result. Depends on rtm_pkg.
`timescale 1ns / 1ps

module rtm_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  rtm_pkg::in_item_t  item,
    input  rtm_pkg::cfg_t      cfg,
    output rtm_pkg::out_item_t result
);

    logic [1:0]  mode_reg,        mode_next;
    logic [63:0] wave_start_reg,  wave_start_next;
    logic [31:0] open_count_reg,  open_count_next;
    logic [31:0] close_count_reg, close_count_next;
    logic [63:0] acc_ticks_reg,   acc_ticks_next;
    logic [63:0] acc_bytes_reg,   acc_bytes_next;
    logic [31:0] iter_count_reg,  iter_count_next;
    logic [63:0] total_ticks_reg, total_ticks_next;
    logic [63:0] min_ticks_reg,   min_ticks_next;
    logic [63:0] max_ticks_reg,   max_ticks_next;

    logic        still;
    logic [1:0]  fault;
    logic        newmin;
    logic [63:0] elapsed;

    assign elapsed = item.timestamp - wave_start_reg;

    always_comb begin
        mode_next        = mode_reg;
        wave_start_next  = wave_start_reg;
        open_count_next  = open_count_reg;
        close_count_next = close_count_reg;
        acc_ticks_next   = acc_ticks_reg;
        acc_bytes_next   = acc_bytes_reg;
        iter_count_next  = iter_count_reg;
        total_ticks_next = total_ticks_reg;
        min_ticks_next   = min_ticks_reg;
        max_ticks_next   = max_ticks_reg;
        still            = 1'b0;
        fault            = rtm_pkg::FAULT_NONE;
        newmin           = 1'b0;

        unique case (item.req_type)
            rtm_pkg::REQ_START_WAVE: begin
                if (mode_reg == rtm_pkg::MODE_UNINIT) begin
                    mode_next      = rtm_pkg::MODE_TESTING;
                    min_ticks_next = '1;
                end else if (mode_reg == rtm_pkg::MODE_COMPLETED) begin
                    mode_next = rtm_pkg::MODE_TESTING;
                end
                wave_start_next = item.timestamp;
            end
            rtm_pkg::REQ_BEGIN_BLOCK: begin
                open_count_next = open_count_reg + 32'd1;
                acc_ticks_next  = acc_ticks_reg - item.timestamp;
            end
            rtm_pkg::REQ_END_BLOCK: begin
                close_count_next = close_count_reg + 32'd1;
                acc_ticks_next   = acc_ticks_reg + item.timestamp;
            end
            rtm_pkg::REQ_ADD_BYTES: begin
                acc_bytes_next = acc_bytes_reg + {32'd0, item.byte_amount};
            end
            rtm_pkg::REQ_CHECK: begin
                if (mode_reg == rtm_pkg::MODE_TESTING) begin
                    if (open_count_reg == 32'd0) begin
                        // No timed region yet: nothing to validate or record.
                        still = 1'b1;
                    end else begin
                        if (open_count_reg != close_count_reg) begin
                            fault = fault | rtm_pkg::FAULT_UNBALANCED;
                        end
                        if (acc_bytes_reg != cfg.target_bytes) begin
                            fault = fault | rtm_pkg::FAULT_BYTES;
                        end
                        if (fault != rtm_pkg::FAULT_NONE) begin
                            mode_next = rtm_pkg::MODE_ERROR;
                        end else if (elapsed > cfg.try_duration_ticks) begin
                            mode_next = rtm_pkg::MODE_COMPLETED;
                        end else begin
                            iter_count_next  = iter_count_reg + 32'd1;
                            total_ticks_next = total_ticks_reg + acc_ticks_reg;
                            if (max_ticks_reg < acc_ticks_reg) begin
                                max_ticks_next = acc_ticks_reg;
                            end
                            if (min_ticks_reg > acc_ticks_reg) begin
                                // A new minimum restarts the idle timeout.
                                min_ticks_next  = acc_ticks_reg;
                                wave_start_next = item.timestamp;
                                newmin          = 1'b1;
                            end
                            open_count_next  = '0;
                            close_count_next = '0;
                            acc_ticks_next   = '0;
                            acc_bytes_next   = '0;
                            still            = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= rtm_pkg::MODE_UNINIT;
            wave_start_reg  <= '0;
            open_count_reg  <= '0;
            close_count_reg <= '0;
            acc_ticks_reg   <= '0;
            acc_bytes_reg   <= '0;
            iter_count_reg  <= '0;
            total_ticks_reg <= '0;
            min_ticks_reg   <= '0;
            max_ticks_reg   <= '0;
        end else if (step) begin
            mode_reg        <= mode_next;
            wave_start_reg  <= wave_start_next;
            open_count_reg  <= open_count_next;
            close_count_reg <= close_count_next;
            acc_ticks_reg   <= acc_ticks_next;
            acc_bytes_reg   <= acc_bytes_next;
            iter_count_reg  <= iter_count_next;
            total_ticks_reg <= total_ticks_next;
            min_ticks_reg   <= min_ticks_next;
            max_ticks_reg   <= max_ticks_next;
        end
    end

    assign result.still_testing = still;
    assign result.run_mode      = mode_next;
    assign result.fault_code    = fault;
    assign result.new_minimum   = newmin;
    assign result.iterations    = iter_count_next;
    assign result.fastest_time  = min_ticks_next;
    assign result.slowest_time  = max_ticks_next;
    assign result.summed_time   = total_ticks_next;

endmodule

@@ rtl/repetition_timing_monitor.sv @@
// Repetition timing monitor: m_valid rises when the result of an accepted input is registered.
// Throughput is one transaction per cycle with m_ready high; the test state update is the loop.
// The input register takes a new transaction while a result still waits on m_ready.
// Reset (aresetn low, synchronous) empties both registers, zeroes all statistics,
// sets the mode to uninitialized and clears both configuration registers.
`timescale 1ns / 1ps

module repetition_timing_monitor (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Event channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rtm_pkg::in_item_t             s_data,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output rtm_pkg::out_item_t            m_data,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtm_pkg::PADDR_W-1:0]   paddr,
    input  logic [rtm_pkg::PDATA_W-1:0]   pwdata,
    output logic [rtm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    // Input register: holds one accepted transaction until the core applies it.
    logic               in_valid_reg;
    rtm_pkg::in_item_t  in_item_reg;

    // Result register: holds one finished result until the sink takes it.
    logic               out_valid_reg;
    rtm_pkg::out_item_t out_item_reg;

    rtm_pkg::cfg_t      cfg;
    rtm_pkg::out_item_t core_result;
    logic               advance;

    // The core applies the held transaction whenever the result register is
    // empty or is being drained in this same cycle. State updates and the
    // result capture happen together, so results leave in event order.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);

    // A new transaction enters when the input register is empty or moves on.
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= core_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // Configuration registers; written by the user only while no event is in flight; unchecked.
    rtm_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Test state, statistics and per-event result.
    rtm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

endmodule

@@ tb/repetition_timing_monitor_test.sv @@
// Self-checking testbench for repetition_timing_monitor: a scoreboard class predicts
// every result from the accepted events, and plain tasks drive the event and APB ports.
// Depends on rtm_pkg and the repetition_timing_monitor RTL.
`timescale 1ns / 1ps

module repetition_timing_monitor_test;
    import rtm_pkg::*;

    // Request codes that the block must treat as no-ops.
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

    localparam int IDLE_PCT      = 11;      // chance per cycle that a side idles
    localparam int HOLD_CYCLES   = 150;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 6;       // settling margin after the last result
    localparam int CYCLE_LIMIT   = 100000;  // far beyond the slowest correct run
    localparam int PRINT_CAP     = 40;      // mismatch lines printed before going quiet

    // Scoreboard: keeps its own copy of the monitor state and configuration,
    // predicts one result per accepted event and compares results in order.
    class rtm_scoreboard;
        logic [63:0] target_bytes;
        logic [63:0] try_ticks;
        logic [1:0]  mode;
        logic [63:0] wave_start;
        logic [31:0] opens;
        logic [31:0] closes;
        logic [63:0] span_ticks;
        logic [63:0] byte_total;
        logic [31:0] iter_count;
        logic [63:0] sum_ticks;
        logic [63:0] min_ticks;
        logic [63:0] max_ticks;
        out_item_t   predicted_stats[$];
        int          errors;
        int          result_count;

        function new();
            target_bytes = '0;
            try_ticks    = '0;
            mode         = MODE_UNINIT;
            wave_start   = '0;
            opens        = '0;
            closes       = '0;
            span_ticks   = '0;
            byte_total   = '0;
            iter_count   = '0;
            sum_ticks    = '0;
            min_ticks    = '0;
            max_ticks    = '0;
            errors       = 0;
            result_count = 0;
        endfunction

        function void set_register(logic idx, logic [63:0] value);
            if (idx == REG_TARGET_BYTES) begin
                target_bytes = value;
            end else begin
                try_ticks = value;
            end
        endfunction

        function int pending();
            return predicted_stats.size();
        endfunction

        // Applies one accepted event to the state and queues the result it causes.
        task note_event(in_item_t ev);
            out_item_t r;
            r = '0;
            case (ev.req_type)
                REQ_START_WAVE: begin
                    if (mode == MODE_UNINIT) begin
                        mode      = MODE_TESTING;
                        min_ticks = '1;
                    end else if (mode == MODE_COMPLETED) begin
                        mode = MODE_TESTING;
                    end
                    wave_start = ev.timestamp;
                end
                REQ_BEGIN_BLOCK: begin
                    opens      = opens + 1;
                    span_ticks = span_ticks - ev.timestamp;
                end
                REQ_END_BLOCK: begin
                    closes     = closes + 1;
                    span_ticks = span_ticks + ev.timestamp;
                end
                REQ_ADD_BYTES: begin
                    byte_total = byte_total + {32'd0, ev.byte_amount};
                end
                REQ_CHECK: begin
                    if (mode == MODE_TESTING) begin
                        if (opens == 0) begin
                            r.still_testing = 1'b1;
                        end else begin
                            if (opens != closes) begin
                                r.fault_code = r.fault_code | FAULT_UNBALANCED;
                            end
                            if (byte_total != target_bytes) begin
                                r.fault_code = r.fault_code | FAULT_BYTES;
                            end
                            if (r.fault_code != FAULT_NONE) begin
                                mode = MODE_ERROR;
                            end else if (ev.timestamp - wave_start > try_ticks) begin
                                mode = MODE_COMPLETED;
                            end else begin
                                iter_count = iter_count + 1;
                                sum_ticks  = sum_ticks + span_ticks;
                                if (max_ticks < span_ticks) begin
                                    max_ticks = span_ticks;
                                end
                                if (min_ticks > span_ticks) begin
                                    min_ticks     = span_ticks;
                                    wave_start    = ev.timestamp;
                                    r.new_minimum = 1'b1;
                                end
                                opens           = '0;
                                closes          = '0;
                                span_ticks      = '0;
                                byte_total      = '0;
                                r.still_testing = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            r.run_mode     = mode;
            r.iterations   = iter_count;
            r.fastest_time = min_ticks;
            r.slowest_time = max_ticks;
            r.summed_time  = sum_ticks;
            predicted_stats.push_back(r);
        endtask

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP) begin
                $display("MISMATCH: %s", msg);
            end
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report($sformatf("result %0d %s: got 0x%0h, predicted 0x%0h",
                                 result_count, name, got, want));
            end
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (predicted_stats.size() == 0) begin
                report($sformatf("result %0d arrived with nothing predicted", result_count));
            end else begin
                want = predicted_stats.pop_front();
                compare_field("still_testing", got.still_testing, want.still_testing);
                compare_field("run_mode", got.run_mode, want.run_mode);
                compare_field("fault_code", got.fault_code, want.fault_code);
                compare_field("new_minimum", got.new_minimum, want.new_minimum);
                compare_field("iterations", got.iterations, want.iterations);
                compare_field("fastest_time", got.fastest_time, want.fastest_time);
                compare_field("slowest_time", got.slowest_time, want.slowest_time);
                compare_field("summed_time", got.summed_time, want.summed_time);
            end
            result_count++;
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    rtm_scoreboard sb;

    // Stimulus bookkeeping. The timestamp generator walks a free-running
    // timer with a per-phase step size and an occasional jump anywhere in
    // the 64-bit range, which is what exercises the wrapping arithmetic.
    int          sent_items;
    int          cycle_count;
    logic [63:0] clock_ts;
    int          ts_step;
    int          ts_jump_pct;
    bit          quiet;          // set: neither side idles
    int          hold_requests;  // bumped by the stimulus to ask for a hold-off
    int          holds_served;
    int          hold_left;

    repetition_timing_monitor dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    // Result side. Every accepted result transaction goes straight to the
    // scoreboard; sampling at the clock edge sees the values from before it.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    // Receiver readiness. Normally m_ready drops in about one cycle of nine;
    // when the stimulus asks for a hold-off it stays low throughout it, so
    // that both pipeline stages fill and the block stalls its input.
    initial begin
        m_ready      <= 1'b0;
        holds_served  = 0;
        hold_left     = 0;
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [63:0] next_ts();
        if ($urandom_range(99) < ts_jump_pct) begin
            clock_ts = {$urandom, $urandom};
        end else begin
            clock_ts = clock_ts + $urandom_range(ts_step);
        end
        return clock_ts;
    endfunction

    // Offers one event transaction and returns at the edge that accepts it.
    // Valid is only lowered for an idle cycle, so back-to-back transactions
    // keep it high without a drop inside one time step.
    task send_event(input logic [2:0] req, input logic [63:0] ts, input logic [31:0] amount);
        in_item_t ev;
        ev.req_type    = req;
        ev.timestamp   = ts;
        ev.byte_amount = amount;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(ev);
        sent_items++;
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task write_config(input logic idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // Stops offering events and waits until every predicted result has come back.
    task wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Harmless noise between events: unused request codes, a restart of the
    // wave timer, or an add of zero bytes.
    task add_noise();
        case ($urandom_range(19))
            0: send_event(3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)),
                          {$urandom, $urandom}, $urandom);
            1: send_event(REQ_START_WAVE, next_ts(), $urandom);
            2: send_event(REQ_ADD_BYTES, {$urandom, $urandom}, '0);
            default: begin
            end
        endcase
    endtask

    // One well-formed iteration: balanced begin/end pairs (now and then in
    // reverse order, which wraps the span), exactly the bytes still owed to
    // reach the target, then a check. Zero pairs gives a check with no begin.
    task random_iteration();
        int          pairs;
        int          k;
        bit          reversed;
        logic [63:0] owed;
        logic [31:0] chunk;
        pairs = $urandom_range(0, 3);
        for (k = 0; k < pairs; k++) begin
            reversed = ($urandom_range(9) == 0);
            send_event(reversed ? REQ_END_BLOCK : REQ_BEGIN_BLOCK, next_ts(), $urandom);
            add_noise();
            send_event(reversed ? REQ_BEGIN_BLOCK : REQ_END_BLOCK, next_ts(), $urandom);
        end
        owed = sb.target_bytes - sb.byte_total;
        while (owed != 0) begin
            if (owed > 64'hFFFF_FFFF) begin
                chunk = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
            end else begin
                chunk = $urandom_range(1) ? owed[31:0] : $urandom_range(0, owed[31:0]);
            end
            send_event(REQ_ADD_BYTES, {$urandom, $urandom}, chunk);
            owed = owed - {32'd0, chunk};
        end
        add_noise();
        send_event(REQ_CHECK, next_ts(), $urandom);
    endtask

    // Random traffic: restart the wave whenever it has completed, otherwise
    // run iterations. The scoreboard state is current once send_event returns.
    task random_traffic(input int count);
        int goal;
        goal = sent_items + count;
        while (sent_items < goal) begin
            if (sb.mode == MODE_TESTING) begin
                random_iteration();
            end else begin
                send_event(REQ_START_WAVE, next_ts(), $urandom);
            end
        end
    endtask

    // Before a new byte target, any iteration left over by a timeout or by a
    // check with no begin gets recorded, so the next phase starts clean. The
    // check uses the wave start time, so it cannot time out.
    task settle_counters();
        if (sb.mode == MODE_COMPLETED) begin
            send_event(REQ_START_WAVE, next_ts(), $urandom);
        end
        if (sb.opens == 0 && sb.byte_total != 0) begin
            send_event(REQ_BEGIN_BLOCK, next_ts(), $urandom);
            send_event(REQ_END_BLOCK, next_ts(), $urandom);
        end
        if (sb.opens != 0) begin
            send_event(REQ_CHECK, sb.wave_start, $urandom);
        end
    endtask

    initial begin
        sb            = new();
        sent_items    = 0;
        hold_requests = 0;
        quiet         = 1'b0;
        clock_ts      = '0;
        ts_step       = 100;
        ts_jump_pct   = 0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_data       <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Target of 100 bytes and a timeout that never fires.
        write_config(REG_TARGET_BYTES, 64'd100);
        write_config(REG_TRY_DURATION, '1);
        // A check before any start answers "not testing".
        send_event(REQ_CHECK, 64'd0, $urandom);
        // Blocks and bytes before the first start still count.
        send_event(REQ_BEGIN_BLOCK, 64'd50, $urandom);
        send_event(REQ_END_BLOCK, 64'd80, $urandom);
        send_event(REQ_ADD_BYTES, {$urandom, $urandom}, 32'd100);
        // First start presets the minimum; the check records that iteration.
        send_event(REQ_START_WAVE, 64'd100, $urandom);
        send_event(REQ_CHECK, 64'd120, $urandom);
        // Unused request codes change nothing.
        send_event(REQ_UNUSED_FIRST, '1, '1);
        send_event(REQ_UNUSED_FIRST + 3'd1, {$urandom, $urandom}, $urandom);
        send_event(REQ_UNUSED_LAST, '0, '0);
        // A check with no begin keeps testing and records nothing.
        send_event(REQ_CHECK, 64'd130, $urandom);
        // A start while testing only moves the wave start time.
        send_event(REQ_START_WAVE, 64'd140, $urandom);
        // A begin at the top of the timer and an end after it wraps.
        send_event(REQ_BEGIN_BLOCK, '1, $urandom);
        send_event(REQ_ADD_BYTES, '1, 32'd60);
        send_event(REQ_ADD_BYTES, '0, 32'd40);
        send_event(REQ_END_BLOCK, 64'd9, $urandom);
        send_event(REQ_CHECK, 64'd200, $urandom);
        // A long span raises the maximum without a new minimum.
        send_event(REQ_BEGIN_BLOCK, 64'd200, $urandom);
        send_event(REQ_END_BLOCK, 64'h8000_0000_0000_1000, $urandom);
        send_event(REQ_ADD_BYTES, {$urandom, $urandom}, 32'd100);
        send_event(REQ_CHECK, 64'd300, $urandom);
        wait_drained();

        // Zero timeout: the next check completes the wave and keeps the
        // counters; a check while completed does nothing; a restart and a
        // check at the same time then record the kept iteration.
        write_config(REG_TARGET_BYTES, '0);
        write_config(REG_TRY_DURATION, '0);
        send_event(REQ_BEGIN_BLOCK, 64'd1000, $urandom);
        send_event(REQ_END_BLOCK, 64'd1001, $urandom);
        send_event(REQ_CHECK, 64'd1002, $urandom);
        send_event(REQ_CHECK, 64'd1003, $urandom);
        send_event(REQ_START_WAVE, 64'd2000, $urandom);
        send_event(REQ_CHECK, 64'd2000, $urandom);
        wait_drained();

        // Phase A: no byte target, endless wave, no idling on either side.
        clock_ts    = 64'd3000;
        ts_step     = 1000;
        ts_jump_pct = 5;
        quiet       = 1'b1;
        write_config(REG_TRY_DURATION, '1);
        random_traffic(100);
        settle_counters();
        wait_drained();
        quiet = 1'b0;

        // Phase B: random target and a short timeout, so waves complete and
        // restart often. Midway the receiver holds off while events keep
        // coming, and later the sender pauses until everything is back.
        ts_step     = 400;
        ts_jump_pct = 2;
        write_config(REG_TARGET_BYTES, {30'd0, 2'($urandom_range(0, 2)), 32'($urandom)});
        write_config(REG_TRY_DURATION, 64'($urandom_range(3000, 20000)));
        random_traffic(60);
        hold_requests++;
        random_traffic(60);
        wait_drained();
        random_traffic(80);
        settle_counters();
        wait_drained();

        // Phase C: a target that needs full 32-bit byte adds, zero timeout
        // and a mostly frozen timer.
        ts_step     = 0;
        ts_jump_pct = 5;
        write_config(REG_TARGET_BYTES, 64'h2_FFFF_FFFD);
        write_config(REG_TRY_DURATION, '0);
        random_traffic(100);
        settle_counters();
        wait_drained();

        // Phase D: small target, moderate timeout.
        ts_step     = 300;
        ts_jump_pct = 3;
        write_config(REG_TARGET_BYTES, 64'($urandom_range(1, 1000)));
        write_config(REG_TRY_DURATION, 64'($urandom_range(500, 5000)));
        random_traffic(50);
        settle_counters();
        wait_drained();

        // Unreachable target plus unbalanced blocks: both fault bits at once,
        // then the sticky error mode ignores starts and checks.
        write_config(REG_TARGET_BYTES, '1);
        send_event(REQ_START_WAVE, next_ts(), $urandom);
        send_event(REQ_BEGIN_BLOCK, next_ts(), $urandom);
        send_event(REQ_BEGIN_BLOCK, next_ts(), $urandom);
        send_event(REQ_END_BLOCK, next_ts(), $urandom);
        send_event(REQ_ADD_BYTES, {$urandom, $urandom}, $urandom);
        send_event(REQ_CHECK, next_ts(), $urandom);
        send_event(REQ_START_WAVE, next_ts(), $urandom);
        send_event(REQ_CHECK, next_ts(), $urandom);
        send_event(REQ_UNUSED_LAST, next_ts(), $urandom);
        send_event(REQ_END_BLOCK, next_ts(), $urandom);
        send_event(REQ_CHECK, next_ts(), $urandom);

        wait_drained();
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
